/* src/i2cm_pkg.sv */
// Shared types and constants for the I2C master bit engine.
package i2cm_pkg;

    localparam int HALF_COUNT_WIDTH    = 16;
    localparam int STRETCH_COUNT_WIDTH = 20;

    localparam int HALF_PERIOD_WIDTH   = 16;
    localparam int STRETCH_LIMIT_WIDTH = 20;
    localparam int CFG_INDEX_WIDTH     = 2;
    localparam int CFG_DATA_WIDTH      = 20;

    localparam logic [HALF_PERIOD_WIDTH-1:0]   HALF_PERIOD_RESET   = 16'd250;
    localparam logic [STRETCH_LIMIT_WIDTH-1:0] STRETCH_LIMIT_RESET = 20'd50000;

    localparam int IN_DEPTH  = 4;
    localparam int OUT_DEPTH = 2;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_HALF_PERIOD   = 2'd0,
        CFG_STRETCH_LIMIT = 2'd1
    } cfg_index_t;

    typedef enum logic [2:0] {
        CMD_IDLE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4
    } cmd_t;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_S_WAIT = 4'd1,
        PH_S_D1   = 4'd2,
        PH_S_D2   = 4'd3,
        PH_P_D1   = 4'd4,
        PH_P_WAIT = 4'd5,
        PH_P_D2   = 4'd6,
        PH_P_D3   = 4'd7,
        PH_W_D    = 4'd8,
        PH_W_WAIT = 4'd9,
        PH_W_H    = 4'd10,
        PH_R_D    = 4'd11,
        PH_R_WAIT = 4'd12,
        PH_R_H    = 4'd13
    } phase_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       scl_in;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       scl_drive_low;
        logic       sda_drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_seen;
    } result_t;

endpackage

/* src/i2c_master_bit_engine.sv */
// Top level of the open-drain I2C master bit engine.
//
// Each input transaction is one system tick: a command (idle, start, stop,
// write byte, read byte), the byte to send, the ACK choice and the sampled
// SCL/SDA levels. Push it while full is low. Every accepted transaction
// yields exactly one result transaction: the line drives, busy, a done
// pulse, the last received byte and the last ACK seen. Results wait in a
// queue; read them while empty is low and pop to take one.
// Each input passes from the input queue through the sequencer step into the
// result queue. Throughput: one transaction per cycle, set by the single
// sequencer step, while the result queue is not full.
// Configuration writes (half period, stretch limit) are taken at any time
// through cfg_valid/cfg_ready; issue them only while the block is idle.
// Reset empties both queues, clears the sequencer's line drives and loads the default
// half period of 250 ticks and stretch limit of 50000 ticks.
// When the receiver stalls, the result queue fills, the sequencer holds,
// then the input queue fills and full rises; nothing is dropped.
module i2c_master_bit_engine
    import i2cm_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [2:0]                 func,
    input  logic [7:0]                 tx_byte,
    input  logic                       send_ack,
    input  logic                       scl_in,
    input  logic                       sda_in,
    output logic                       empty,
    input  logic                       pop,
    output logic                       scl_drive_low,
    output logic                       sda_drive_low,
    output logic                       busy_res,
    output logic                       done_res,
    output logic [7:0]                 rx_byte,
    output logic                       ack_seen,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

    logic    item_valid;
    logic    item_take;
    item_t   item;
    logic    res_full;
    logic    res_push;
    result_t res;
    result_t head;

    i2cm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .func       (func),
        .tx_byte    (tx_byte),
        .send_ack   (send_ack),
        .scl_in     (scl_in),
        .sda_in     (sda_in),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item)
    );

    i2cm_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item),
        .res_full   (res_full),
        .res_push   (res_push),
        .res        (res)
    );

    i2cm_result_queue u_result_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_full (res_full),
        .res      (res),
        .empty    (empty),
        .pop      (pop),
        .head     (head)
    );

    assign scl_drive_low = head.scl_drive_low;
    assign sda_drive_low = head.sda_drive_low;
    assign busy_res      = head.busy_res;
    assign done_res      = head.done_res;
    assign rx_byte       = head.rx_byte;
    assign ack_seen      = head.ack_seen;

endmodule

/* src/i2cm_front.sv */
// Front end: decodes incoming commands and buffers them for the engine.
module i2cm_front
    import i2cm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [2:0] func,
    input  logic [7:0] tx_byte,
    input  logic       send_ack,
    input  logic       scl_in,
    input  logic       sda_in,
    output logic       item_valid,
    input  logic       item_take,
    output item_t      item
);

    localparam int PTR_W = (IN_DEPTH > 1) ? $clog2(IN_DEPTH) : 1;
    localparam int CNT_W = $clog2(IN_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(IN_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(IN_DEPTH);

    item_t            mem [IN_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    cmd_t             cmd;
    logic             wr_en;
    logic             rd_en;

    always_comb
    begin
        unique case (func)
            3'd1:    cmd = CMD_START;
            3'd2:    cmd = CMD_STOP;
            3'd3:    cmd = CMD_WRITE;
            3'd4:    cmd = CMD_READ;
            default: cmd = CMD_IDLE;
        endcase
    end

    assign full       = (count_reg == DEPTH_CNT);
    assign item_valid = (count_reg != '0);
    assign wr_en      = push && !full;
    assign rd_en      = item_take && item_valid;
    assign item       = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= '{cmd: cmd, tx_byte: tx_byte, send_ack: send_ack,
                                 scl_in: scl_in, sda_in: sda_in};
        end
    end

endmodule

/* src/i2cm_engine.sv */
// Bus sequencer: runs start, stop, write and read one tick per item.
module i2cm_engine
    import i2cm_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    input  logic                       item_valid,
    output logic                       item_take,
    input  item_t                      item,
    input  logic                       res_full,
    output logic                       res_push,
    output result_t                    res
);

    localparam int HCW  = HALF_COUNT_WIDTH;
    localparam int SCW  = STRETCH_COUNT_WIDTH;
    localparam int HCMP = (HCW > HALF_PERIOD_WIDTH) ? HCW : HALF_PERIOD_WIDTH;
    localparam int SCMP = (SCW > STRETCH_LIMIT_WIDTH) ? SCW : STRETCH_LIMIT_WIDTH;

    logic [HALF_PERIOD_WIDTH-1:0]   half_period_reg;
    logic [STRETCH_LIMIT_WIDTH-1:0] stretch_limit_reg;

    phase_t         phase_reg, phase_next;
    cmd_t           current_command_reg, current_command_next;
    logic [3:0]     bit_count_reg, bit_count_next;
    logic [HCW-1:0] half_counter_reg, half_counter_next;
    logic [SCW-1:0] stretch_counter_reg, stretch_counter_next;
    logic [7:0]     shift_reg, shift_next;
    logic           ack_flag_reg, ack_flag_next;
    logic           ack_choice_reg, ack_choice_next;
    logic           scl_low_reg, scl_low_next;
    logic           sda_low_reg, sda_low_next;
    logic [7:0]     rx_hold_reg, rx_hold_next;

    logic           step;
    logic [HCW:0]   half_inc;
    logic [HCW-1:0] half_sat;
    logic [SCW:0]   stretch_inc;
    logic [SCW-1:0] stretch_sat;
    logic [SCW-1:0] stretch_step;
    logic           delay_end;
    logic           wait_end;
    logic           done;
    logic [3:0]     bit_count_inc;
    logic [7:0]     shift_left;

    assign cfg_ready = 1'b1;
    assign step      = item_valid && !res_full;
    assign item_take = step;
    assign res_push  = step;

    always_comb
    begin
        half_inc     = {1'b0, half_counter_reg} + 1'b1;
        half_sat     = half_inc[HCW] ? '1 : half_inc[HCW-1:0];
        delay_end    = (HCMP'(half_sat) >= HCMP'(half_period_reg)) || (half_sat == '1);
        stretch_inc  = {1'b0, stretch_counter_reg} + 1'b1;
        stretch_sat  = stretch_inc[SCW] ? '1 : stretch_inc[SCW-1:0];
        stretch_step = item.scl_in ? stretch_counter_reg : stretch_sat;
        wait_end     = item.scl_in || (SCMP'(stretch_sat) >= SCMP'(stretch_limit_reg))
                       || (stretch_sat == '1);
        bit_count_inc = bit_count_reg + 1'b1;
        shift_left    = {shift_reg[6:0], 1'b0};
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                unique case (item.cmd)
                    CMD_START: phase_next = PH_S_WAIT;
                    CMD_STOP:  phase_next = PH_P_D1;
                    CMD_WRITE: phase_next = PH_W_D;
                    CMD_READ:  phase_next = PH_R_D;
                    default:   phase_next = PH_IDLE;
                endcase
            end
            PH_S_WAIT: if (wait_end)  phase_next = PH_S_D1;
            PH_S_D1:   if (delay_end) phase_next = PH_S_D2;
            PH_S_D2:   if (delay_end) phase_next = PH_IDLE;
            PH_P_D1:   if (delay_end) phase_next = PH_P_WAIT;
            PH_P_WAIT: if (wait_end)  phase_next = PH_P_D2;
            PH_P_D2:   if (delay_end) phase_next = PH_P_D3;
            PH_P_D3:   if (delay_end) phase_next = PH_IDLE;
            PH_W_D:    if (delay_end) phase_next = PH_W_WAIT;
            PH_W_WAIT: if (wait_end)  phase_next = PH_W_H;
            PH_W_H:
            begin
                if (delay_end)
                begin
                    phase_next = (bit_count_reg < BITS_PER_BYTE) ? PH_W_D : PH_IDLE;
                end
            end
            PH_R_D:    if (delay_end) phase_next = PH_R_WAIT;
            PH_R_WAIT: if (wait_end)  phase_next = PH_R_H;
            PH_R_H:
            begin
                if (delay_end)
                begin
                    phase_next = (bit_count_reg < BITS_PER_BYTE) ? PH_R_D : PH_IDLE;
                end
            end
            default:   phase_next = PH_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        current_command_next = current_command_reg;
        bit_count_next       = bit_count_reg;
        half_counter_next    = half_counter_reg;
        stretch_counter_next = stretch_counter_reg;
        shift_next           = shift_reg;
        ack_flag_next        = ack_flag_reg;
        ack_choice_next      = ack_choice_reg;
        scl_low_next         = scl_low_reg;
        sda_low_next         = sda_low_reg;
        rx_hold_next         = rx_hold_reg;
        done                 = 1'b0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (item.cmd != CMD_IDLE)
                begin
                    current_command_next = item.cmd;
                end
                unique case (item.cmd)
                    CMD_START:
                    begin
                        sda_low_next         = 1'b0;
                        stretch_counter_next = '0;
                        scl_low_next         = 1'b0;
                    end
                    CMD_STOP:
                    begin
                        sda_low_next      = 1'b1;
                        half_counter_next = '0;
                    end
                    CMD_WRITE:
                    begin
                        shift_next        = item.tx_byte;
                        bit_count_next    = '0;
                        sda_low_next      = !item.tx_byte[7];
                        half_counter_next = '0;
                    end
                    CMD_READ:
                    begin
                        shift_next        = '0;
                        bit_count_next    = '0;
                        ack_choice_next   = item.send_ack;
                        sda_low_next      = 1'b0;
                        half_counter_next = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            PH_S_WAIT, PH_P_WAIT, PH_W_WAIT, PH_R_WAIT:
            begin
                stretch_counter_next = stretch_step;
                if (wait_end)
                begin
                    half_counter_next = '0;
                end
            end
            PH_S_D1, PH_P_D2:
            begin
                half_counter_next = half_sat;
                if (delay_end)
                begin
                    sda_low_next      = (phase_reg == PH_S_D1);
                    half_counter_next = '0;
                end
            end
            PH_S_D2:
            begin
                half_counter_next = half_sat;
                if (delay_end)
                begin
                    scl_low_next = 1'b1;
                    done         = 1'b1;
                end
            end
            PH_P_D3:
            begin
                half_counter_next = half_sat;
                if (delay_end)
                begin
                    done = 1'b1;
                end
            end
            PH_P_D1, PH_W_D, PH_R_D:
            begin
                half_counter_next = half_sat;
                if (delay_end)
                begin
                    stretch_counter_next = '0;
                    scl_low_next         = 1'b0;
                end
            end
            PH_W_H:
            begin
                half_counter_next = half_sat;
                if (delay_end)
                begin
                    scl_low_next = 1'b1;
                    if (bit_count_reg < BITS_PER_BYTE)
                    begin
                        shift_next        = shift_left;
                        bit_count_next    = bit_count_inc;
                        sda_low_next      = (bit_count_inc < BITS_PER_BYTE) ? !shift_left[7]
                                                                            : 1'b0;
                        half_counter_next = '0;
                    end
                    else
                    begin
                        ack_flag_next = !item.sda_in;
                        done          = 1'b1;
                    end
                end
            end
            PH_R_H:
            begin
                half_counter_next = half_sat;
                if (delay_end)
                begin
                    scl_low_next = 1'b1;
                    if (bit_count_reg < BITS_PER_BYTE)
                    begin
                        shift_next        = {shift_reg[6:0], item.sda_in};
                        bit_count_next    = bit_count_inc;
                        half_counter_next = '0;
                        if (bit_count_inc == BITS_PER_BYTE)
                        begin
                            sda_low_next = ack_choice_reg;
                        end
                    end
                    else
                    begin
                        sda_low_next = 1'b0;
                        rx_hold_next = shift_reg;
                        done         = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign res = '{scl_drive_low: scl_low_next,
                   sda_drive_low: sda_low_next,
                   busy_res:      (phase_next != PH_IDLE),
                   done_res:      done,
                   rx_byte:       rx_hold_next,
                   ack_seen:      ack_flag_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg   <= HALF_PERIOD_RESET;
            stretch_limit_reg <= STRETCH_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_HALF_PERIOD)
            begin
                half_period_reg <= cfg_data[HALF_PERIOD_WIDTH-1:0];
            end
            else if (cfg_index == CFG_STRETCH_LIMIT)
            begin
                stretch_limit_reg <= cfg_data[STRETCH_LIMIT_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_IDLE;
            current_command_reg <= CMD_IDLE;
            bit_count_reg       <= '0;
            half_counter_reg    <= '0;
            stretch_counter_reg <= '0;
            shift_reg           <= '0;
            ack_flag_reg        <= 1'b0;
            ack_choice_reg      <= 1'b0;
            scl_low_reg         <= 1'b0;
            sda_low_reg         <= 1'b0;
            rx_hold_reg         <= '0;
        end
        else if (step)
        begin
            phase_reg           <= phase_next;
            current_command_reg <= current_command_next;
            bit_count_reg       <= bit_count_next;
            half_counter_reg    <= half_counter_next;
            stretch_counter_reg <= stretch_counter_next;
            shift_reg           <= shift_next;
            ack_flag_reg        <= ack_flag_next;
            ack_choice_reg      <= ack_choice_next;
            scl_low_reg         <= scl_low_next;
            sda_low_reg         <= sda_low_next;
            rx_hold_reg         <= rx_hold_next;
        end
    end

    a_cmd_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step && (phase_reg == PH_IDLE) && (item.cmd != CMD_IDLE) |=> (phase_reg != PH_IDLE))
        else $error("command did not start a sequence");

    a_write_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_W_D || phase_reg == PH_W_WAIT || phase_reg == PH_W_H)
        |-> (current_command_reg == CMD_WRITE))
        else $error("write phase without write command");

    a_read_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_R_D || phase_reg == PH_R_WAIT || phase_reg == PH_R_H)
        |-> (current_command_reg == CMD_READ))
        else $error("read phase without read command");

    a_bit_count: assert property (@(posedge clk) disable iff (!rst_n)
        bit_count_reg <= BITS_PER_BYTE)
        else $error("bit count overrun");

    a_clock_low_after_bit: assert property (@(posedge clk) disable iff (!rst_n)
        step && delay_end && (phase_reg == PH_W_H || phase_reg == PH_R_H) |=> scl_low_reg)
        else $error("SCL not pulled low after data bit");

endmodule

/* src/i2cm_result_queue.sv */
// Result queue: holds finished results until the receiver pops them.
module i2cm_result_queue
    import i2cm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    res_push,
    output logic    res_full,
    input  result_t res,
    output logic    empty,
    input  logic    pop,
    output result_t head
);

    localparam int PTR_W = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
    localparam int CNT_W = $clog2(OUT_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(OUT_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(OUT_DEPTH);

    result_t          mem [OUT_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             wr_en;
    logic             rd_en;

    assign res_full = (count_reg == DEPTH_CNT);
    assign empty    = (count_reg == '0);
    assign wr_en    = res_push && !res_full;
    assign rd_en    = pop && !empty;
    assign head     = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= res;
        end
    end

endmodule

/* bench/i2c_master_bit_engine_tb.sv */
// Testbench for the I2C master bit engine: a tick-by-tick line predictor checked through both queues.
module i2c_master_bit_engine_tb;
    import i2cm_pkg::*;

    localparam logic [2:0] FUNC_RSVD_LO = 3'd5;
    localparam logic [2:0] FUNC_RSVD_HI = 3'd7;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE_HI = 2'd3;
    localparam int LONG_HOLD_CYCLES = 120;
    localparam int SETTLE_CYCLES    = 12;

    class i2c_line_scoreboard;
        logic [HALF_PERIOD_WIDTH-1:0]   half_period;
        logic [STRETCH_LIMIT_WIDTH-1:0] stretch_limit;
        phase_t                         phase;
        logic [2:0]                     cur_cmd;
        logic [3:0]                     bit_cnt;
        logic [HALF_COUNT_WIDTH-1:0]    half_ctr;
        logic [STRETCH_COUNT_WIDTH-1:0] stretch_ctr;
        logic [7:0]                     shifter;
        logic                           ack_flag;
        logic                           ack_choice;
        logic                           scl_low;
        logic                           sda_low;
        logic [7:0]                     rx_hold;
        result_t                        expected_lines[$];
        int                             errors;

        function new();
            half_period   = HALF_PERIOD_RESET;
            stretch_limit = STRETCH_LIMIT_RESET;
            phase         = PH_IDLE;
            cur_cmd       = CMD_IDLE;
            bit_cnt       = '0;
            half_ctr      = '0;
            stretch_ctr   = '0;
            shifter       = '0;
            ack_flag      = 1'b0;
            ack_choice    = 1'b0;
            scl_low       = 1'b0;
            sda_low       = 1'b0;
            rx_hold       = '0;
            errors        = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] data);
            if (idx == CFG_HALF_PERIOD)
                half_period = data[HALF_PERIOD_WIDTH-1:0];
            else if (idx == CFG_STRETCH_LIMIT)
                stretch_limit = data[STRETCH_LIMIT_WIDTH-1:0];
        endfunction

        function bit is_idle();
            return phase == PH_IDLE;
        endfunction

        function int pending();
            return expected_lines.size();
        endfunction

        function bit delay_step();
            if (half_ctr != '1)
                half_ctr = half_ctr + 1'b1;
            return (half_ctr >= half_period) || (half_ctr == '1);
        endfunction

        function bit wait_step(logic scl);
            if (scl)
                return 1'b1;
            if (stretch_ctr != '1)
                stretch_ctr = stretch_ctr + 1'b1;
            return (stretch_ctr >= stretch_limit) || (stretch_ctr == '1);
        endfunction

        function void go_delay(phase_t p);
            half_ctr = '0;
            phase    = p;
        endfunction

        function void go_wait(phase_t p);
            stretch_ctr = '0;
            scl_low     = 1'b0;
            phase       = p;
        endfunction

        function void note_tick(logic [2:0] f, logic [7:0] txb, logic sack, logic scl, logic sda);
            result_t r;
            logic    done;
            done = 1'b0;
            case (phase)
                PH_IDLE: begin
                    if (f >= CMD_START && f <= CMD_READ)
                        cur_cmd = f;
                    if (f == CMD_START) begin
                        sda_low = 1'b0;
                        go_wait(PH_S_WAIT);
                    end else if (f == CMD_STOP) begin
                        sda_low = 1'b1;
                        go_delay(PH_P_D1);
                    end else if (f == CMD_WRITE) begin
                        shifter = txb;
                        bit_cnt = '0;
                        sda_low = ~txb[7];
                        go_delay(PH_W_D);
                    end else if (f == CMD_READ) begin
                        shifter    = '0;
                        bit_cnt    = '0;
                        ack_choice = sack;
                        sda_low    = 1'b0;
                        go_delay(PH_R_D);
                    end
                end
                PH_S_WAIT: if (wait_step(scl)) go_delay(PH_S_D1);
                PH_S_D1: begin
                    if (delay_step()) begin
                        sda_low = 1'b1;
                        go_delay(PH_S_D2);
                    end
                end
                PH_S_D2: begin
                    if (delay_step()) begin
                        scl_low = 1'b1;
                        phase   = PH_IDLE;
                        done    = 1'b1;
                    end
                end
                PH_P_D1: if (delay_step()) go_wait(PH_P_WAIT);
                PH_P_WAIT: if (wait_step(scl)) go_delay(PH_P_D2);
                PH_P_D2: begin
                    if (delay_step()) begin
                        sda_low = 1'b0;
                        go_delay(PH_P_D3);
                    end
                end
                PH_P_D3: begin
                    if (delay_step()) begin
                        phase = PH_IDLE;
                        done  = 1'b1;
                    end
                end
                PH_W_D: if (delay_step()) go_wait(PH_W_WAIT);
                PH_W_WAIT: if (wait_step(scl)) go_delay(PH_W_H);
                PH_W_H: begin
                    if (delay_step()) begin
                        scl_low = 1'b1;
                        if (bit_cnt < BITS_PER_BYTE) begin
                            shifter = shifter << 1;
                            bit_cnt = bit_cnt + 1'b1;
                            sda_low = (bit_cnt < BITS_PER_BYTE) ? ~shifter[7] : 1'b0;
                            go_delay(PH_W_D);
                        end else begin
                            ack_flag = ~sda;
                            phase    = PH_IDLE;
                            done     = 1'b1;
                        end
                    end
                end
                PH_R_D: if (delay_step()) go_wait(PH_R_WAIT);
                PH_R_WAIT: if (wait_step(scl)) go_delay(PH_R_H);
                PH_R_H: begin
                    if (delay_step()) begin
                        scl_low = 1'b1;
                        if (bit_cnt < BITS_PER_BYTE) begin
                            shifter = {shifter[6:0], sda};
                            bit_cnt = bit_cnt + 1'b1;
                            if (bit_cnt == BITS_PER_BYTE)
                                sda_low = ack_choice;
                            go_delay(PH_R_D);
                        end else begin
                            sda_low = 1'b0;
                            rx_hold = shifter;
                            phase   = PH_IDLE;
                            done    = 1'b1;
                        end
                    end
                end
                default: phase = PH_IDLE;
            endcase
            r.scl_drive_low = scl_low;
            r.sda_drive_low = sda_low;
            r.busy_res      = (phase != PH_IDLE);
            r.done_res      = done;
            r.rx_byte       = rx_hold;
            r.ack_seen      = ack_flag;
            expected_lines.push_back(r);
        endfunction

        function void compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_lines.size() == 0) begin
                $error("result transaction with nothing expected");
                errors++;
                return;
            end
            want = expected_lines.pop_front();
            compare_field("scl_drive_low", 8'(want.scl_drive_low), 8'(got.scl_drive_low));
            compare_field("sda_drive_low", 8'(want.sda_drive_low), 8'(got.sda_drive_low));
            compare_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
            compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
            compare_field("rx_byte", want.rx_byte, got.rx_byte);
            compare_field("ack_seen", 8'(want.ack_seen), 8'(got.ack_seen));
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       push;
    logic                       full;
    logic [2:0]                 func;
    logic [7:0]                 tx_byte;
    logic                       send_ack;
    logic                       scl_in;
    logic                       sda_in;
    logic                       empty;
    logic                       pop;
    logic                       scl_drive_low;
    logic                       sda_drive_low;
    logic                       busy_res;
    logic                       done_res;
    logic [7:0]                 rx_byte;
    logic                       ack_seen;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data;

    i2c_line_scoreboard sb = new();
    logic [2:0]         cmd_plan[$];
    bit                 quiet    = 1'b0;
    bit                 hold_req = 1'b0;

    i2c_master_bit_engine dut (.*);

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #2000000;
        $display("i2c_master_bit_engine regression: fail");
        $finish;
    end

    task automatic send_tick(input logic [2:0] f, input logic [7:0] b, input logic sa,
                             input logic scl, input logic sda);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 7) == 0)
            gap = $urandom_range(1, 11);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push     <= 1'b1;
        func     <= f;
        tx_byte  <= b;
        send_ack <= sa;
        scl_in   <= scl;
        sda_in   <= sda;
        do @(posedge clk); while (full);
        sb.note_tick(f, b, sa, scl, sda);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, data);
    endtask

    task automatic settle_config(input logic [HALF_PERIOD_WIDTH-1:0] hp,
                                 input logic [STRETCH_LIMIT_WIDTH-1:0] sl);
        logic [CFG_DATA_WIDTH-1:0] hp_word;
        drain();
        hp_word = CFG_DATA_WIDTH'($urandom);
        hp_word[HALF_PERIOD_WIDTH-1:0] = hp;
        write_reg(CFG_HALF_PERIOD, hp_word);
        write_reg(CFG_STRETCH_LIMIT, sl);
        write_reg(CFG_INDEX_WIDTH'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
                  CFG_DATA_WIDTH'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // command, then idle ticks until the sequencer is free again
    task automatic run_cmd(input logic [2:0] f, input logic [7:0] b, input logic sa,
                           input logic scl_lo);
        send_tick(f, b, sa, 1'b1, 1'($urandom));
        while (!sb.is_idle())
            send_tick(CMD_IDLE, 8'($urandom), 1'($urandom), ~scl_lo, 1'($urandom));
    endtask

    task automatic plan_transaction();
        int n;
        if ($urandom_range(0, 99) < 15) begin
            cmd_plan.push_back(3'($urandom_range(0, 7)));
        end else begin
            cmd_plan.push_back(CMD_START);
            cmd_plan.push_back(CMD_WRITE);
            n = $urandom_range(0, 3);
            repeat (n)
                cmd_plan.push_back($urandom_range(0, 1) ? CMD_WRITE : CMD_READ);
            cmd_plan.push_back(CMD_STOP);
        end
    endtask

    task automatic random_items(input int n, input int scl_low_pct);
        logic [2:0] f;
        for (int i = 0; i < n; i++) begin
            if (sb.is_idle()) begin
                if (cmd_plan.size() == 0)
                    plan_transaction();
                f = cmd_plan.pop_front();
            end else begin
                f = 3'($urandom_range(0, 7));
            end
            send_tick(f, 8'($urandom), 1'($urandom),
                      ($urandom_range(0, 99) >= scl_low_pct), 1'($urandom));
        end
    endtask

    task automatic run_phase(input logic [HALF_PERIOD_WIDTH-1:0] hp,
                             input logic [STRETCH_LIMIT_WIDTH-1:0] sl,
                             input int n, input int scl_low_pct,
                             input bit long_hold, input bit mid_pause);
        settle_config(hp, sl);
        if (long_hold)
            hold_req = 1'b1;
        if (mid_pause) begin
            random_items(n / 2, scl_low_pct);
            drain();
            random_items(n - n / 2, scl_low_pct);
        end else begin
            random_items(n, scl_low_pct);
        end
    endtask

    // result side
    initial begin
        int      stall_left;
        result_t got;
        stall_left = 0;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (pop && !empty) begin
                got.scl_drive_low = scl_drive_low;
                got.sda_drive_low = sda_drive_low;
                got.busy_res      = busy_res;
                got.done_res      = done_res;
                got.rx_byte       = rx_byte;
                got.ack_seen      = ack_seen;
                sb.check_result(got);
            end
            if (hold_req) begin
                pop <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                pop <= 1'b1;
            end else begin
                if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0)
                    stall_left = $urandom_range(1, 11);
                if (stall_left > 0) begin
                    stall_left--;
                    pop <= 1'b0;
                end else begin
                    pop <= 1'b1;
                end
            end
        end
    end

    // stimulus
    initial begin
        rst_n     <= 1'b0;
        push      <= 1'b0;
        func      <= CMD_IDLE;
        tx_byte   <= '0;
        send_ack  <= 1'b0;
        scl_in    <= 1'b1;
        sda_in    <= 1'b1;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_HALF_PERIOD;
        cfg_data  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        random_items(30, 10);

        settle_config(16'd1, 20'd3);
        run_cmd(CMD_START, 8'h00, 1'b0, 1'b0);
        run_cmd(CMD_WRITE, 8'h00, 1'b0, 1'b0);
        run_cmd(CMD_WRITE, 8'hFF, 1'b1, 1'b1);
        run_cmd(CMD_READ, 8'hFF, 1'b1, 1'b0);
        run_cmd(CMD_READ, 8'h00, 1'b0, 1'b1);
        run_cmd(CMD_START, 8'h5A, 1'b0, 1'b1);
        run_cmd(CMD_STOP, 8'h00, 1'b0, 1'b1);
        run_cmd(CMD_STOP, 8'hA5, 1'b1, 1'b0);
        for (int k = FUNC_RSVD_LO; k <= FUNC_RSVD_HI; k++)
            run_cmd(3'(k), 8'($urandom), 1'($urandom), 1'b0);
        run_cmd(CMD_IDLE, 8'hFF, 1'b1, 1'b0);

        run_phase(16'd0, 20'd0, 150, 20, 1'b0, 1'b0);
        run_phase(16'd1, 20'd1, 200, 15, 1'b0, 1'b0);
        run_phase(16'd2, 20'd5, 250, 20, 1'b1, 1'b0);
        run_phase(16'd3, 20'd2, 200, 10, 1'b0, 1'b0);
        run_phase(16'd5, 20'd12, 150, 25, 1'b0, 1'b0);
        run_phase(16'd65535, 20'd1048575, 120, 10, 1'b0, 1'b0);
        run_phase(16'd1, 20'd1048575, 150, 40, 1'b0, 1'b0);
        run_phase(16'd2, 20'd30, 150, 90, 1'b0, 1'b0);
        run_phase(16'd4, 20'd3, 200, 15, 1'b0, 1'b1);
        quiet = 1'b1;
        run_phase(16'd2, 20'd4, 250, 10, 1'b0, 1'b0);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("i2c_master_bit_engine regression: pass");
        else
            $display("i2c_master_bit_engine regression: fail");
        $finish;
    end

endmodule
